[src/afsc_pkg.sv]
// Package for the accent-folding string compare unit.
// Holds code point widths, fold tables, verdict and order codes shared by all modules.
// No dependencies.
package afsc_pkg;

   localparam int CP_W    = 21;
   localparam int ORDER_W = 2;
   localparam int CHAR_W  = 8;

   localparam logic [CP_W-1:0] UPPER_FIRST = 21'h000041;
   localparam logic [CP_W-1:0] UPPER_LAST  = 21'h00005A;
   localparam logic [CP_W-1:0] CASE_OFFSET = 21'h000020;
   localparam logic [CP_W-1:0] ASCII_END   = 21'h000080;
   localparam logic [CP_W-1:0] LATIN1_BASE = 21'h0000C0;
   localparam logic [CP_W-1:0] EXT_A_BASE  = 21'h000100;
   localparam logic [CP_W-1:0] EXT_A_LAST  = 21'h00017F;

   localparam logic [CHAR_W-1:0] NO_BASE_CHAR = ".";

   // base letter for U+00C0..U+00FF, first entry in the top bits
   localparam logic [0:63][CHAR_W-1:0] LATIN1_ROM = {
      "aaaaaaaceeeeiiii",
      "dnooooo.ouuuuy.s",
      "aaaaaaaceeeeiiii",
      "dnooooo.ouuuuy.y"
   };

   // base letter for U+0100..U+017F
   localparam logic [0:127][CHAR_W-1:0] EXT_A_ROM = {
      "aaaaaaccccccccdd",
      "ddeeeeeeeeeegggg",
      "gggghhhhiiiiiiii",
      "iiiijjkkklllllll",
      "lllnnnnnnnnnoooo",
      "oooorrrrrrssssss",
      "ssttttttuuuuuuuu",
      "uuuuwwyyyzzzzzzs"
   };

   typedef enum logic [1:0] {
      VERDICT_UNDECIDED,
      VERDICT_LESS,
      VERDICT_EQUAL,
      VERDICT_GREATER
   } verdict_type;

   localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'b11;
   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'b01;

   typedef struct packed {
      logic [CP_W-1:0] fold_key;
      logic [CP_W-1:0] case_key;
      logic            ended;
   } key_type;

   typedef struct packed {
      logic fire;
      logic last;
   } step_type;

endpackage

[src/afsc_fold.sv]
// Key generation for one code point: ASCII case key and accent-folded primary key.
// Depends on afsc_pkg for the fold tables.
module afsc_fold import afsc_pkg::*; (
   input  logic [CP_W-1:0] code_point,
   output key_type         key
);

   logic [CP_W-1:0]   case_key;
   logic [CHAR_W-1:0] latin1_char;
   logic [CHAR_W-1:0] ext_a_char;

   always_comb begin
      if (code_point >= UPPER_FIRST && code_point <= UPPER_LAST) begin
         case_key = code_point + CASE_OFFSET;
      end else begin
         case_key = code_point;
      end
      latin1_char = LATIN1_ROM[code_point[5:0]];
      ext_a_char  = EXT_A_ROM[code_point[6:0]];

      key.case_key = case_key;
      key.ended    = (code_point == '0);
      if (code_point < ASCII_END) begin
         key.fold_key = case_key;
      end else if (code_point >= LATIN1_BASE && code_point < EXT_A_BASE) begin
         // keep the code point where no base letter exists
         key.fold_key = (latin1_char == NO_BASE_CHAR) ? code_point
                                                      : {{(CP_W-CHAR_W){1'b0}}, latin1_char};
      end else if (code_point >= EXT_A_BASE && code_point <= EXT_A_LAST) begin
         key.fold_key = {{(CP_W-CHAR_W){1'b0}}, ext_a_char};
      end else begin
         key.fold_key = code_point;
      end
   end

endmodule

[src/afsc_verdict.sv]
// Verdict state for one string pair: primary and secondary verdicts and end flag.
// Depends on afsc_pkg; takes the keys from two afsc_fold instances.
module afsc_verdict import afsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  key_type            key_a,
   input  key_type            key_b,
   output logic [ORDER_W-1:0] order
);

   verdict_type primary_ff, primary_in;
   verdict_type secondary_ff, secondary_in;
   logic        ended_ff, ended_in;

   verdict_type primary_step, secondary_step, end_verdict, final_verdict;

   always_comb begin
      if (!key_a.ended) begin
         end_verdict = VERDICT_GREATER;
      end else if (!key_b.ended) begin
         end_verdict = VERDICT_LESS;
      end else begin
         end_verdict = VERDICT_EQUAL;
      end

      primary_step   = primary_ff;
      secondary_step = secondary_ff;
      ended_in       = ended_ff;
      if (!ended_ff) begin
         if (key_a.ended || key_b.ended) begin
            ended_in = 1'b1;
            if (primary_ff == VERDICT_UNDECIDED && end_verdict != VERDICT_EQUAL) begin
               primary_step = end_verdict;
            end
            if (secondary_ff == VERDICT_UNDECIDED) begin
               secondary_step = end_verdict;
            end
         end else begin
            if (primary_ff == VERDICT_UNDECIDED && key_a.fold_key != key_b.fold_key) begin
               primary_step = (key_a.fold_key < key_b.fold_key) ? VERDICT_LESS
                                                                 : VERDICT_GREATER;
            end
            if (secondary_ff == VERDICT_UNDECIDED && key_a.case_key != key_b.case_key) begin
               secondary_step = (key_a.case_key < key_b.case_key) ? VERDICT_LESS
                                                                   : VERDICT_GREATER;
            end
         end
      end

      // implicit end of both strings after the last word
      if (primary_step != VERDICT_UNDECIDED) begin
         final_verdict = primary_step;
      end else if (secondary_step != VERDICT_UNDECIDED) begin
         final_verdict = secondary_step;
      end else begin
         final_verdict = VERDICT_EQUAL;
      end

      unique case (final_verdict)
         VERDICT_LESS:    order = ORDER_LESS;
         VERDICT_GREATER: order = ORDER_GREATER;
         default:         order = ORDER_EQUAL;
      endcase

      primary_in   = primary_ff;
      secondary_in = secondary_ff;
      if (step.fire) begin
         if (step.last) begin
            primary_in   = VERDICT_UNDECIDED;
            secondary_in = VERDICT_UNDECIDED;
            ended_in     = 1'b0;
         end else begin
            primary_in   = primary_step;
            secondary_in = secondary_step;
         end
      end else begin
         ended_in = ended_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff   <= VERDICT_UNDECIDED;
         secondary_ff <= VERDICT_UNDECIDED;
         ended_ff     <= 1'b0;
      end else begin
         primary_ff   <= primary_in;
         secondary_ff <= secondary_in;
         ended_ff     <= ended_in;
      end
   end

endmodule

[src/accent_fold_string_compare_unit.sv]
// Top level of the accent-folding string compare unit.
// Depends on afsc_pkg, afsc_fold and afsc_verdict.
//
// Each input word carries one code point of each string (0 marks the end of that
// string) and tlast on the final pair. One word is taken every clock cycle unless a
// last word waits in the input register for a full output register. A word passes
// the input register, then the folding ROMs and key compare; the verdict for a pair
// is written to the output register as the last word advances, as -1, 0 or 1 in
// two's complement. Words before the last give no result and do not wait for output.
module accent_fold_string_compare_unit import afsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // char_a [20:0], char_b [41:21], zero [47:42]
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // order [1:0], zero [7:2]
);

   logic              s1_valid_ff, s1_valid_in;
   logic [CP_W-1:0]   s1_char_a_ff;
   logic [CP_W-1:0]   s1_char_b_ff;
   logic              s1_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ORDER_W-1:0] rsp_order_ff;

   logic               accept;
   logic               advance;
   logic               out_free;
   step_type           step;
   key_type            key_a, key_b;
   logic [ORDER_W-1:0] order;

   afsc_fold u_fold_a (
      .code_point (s1_char_a_ff),
      .key        (key_a)
   );

   afsc_fold u_fold_b (
      .code_point (s1_char_b_ff),
      .key        (key_b)
   );

   afsc_verdict u_verdict (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .key_a (key_a),
      .key_b (key_b),
      .order (order)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      advance      = s1_valid_ff && (!s1_last_ff || out_free);
      req_tready   = !s1_valid_ff || advance;
      accept       = req_tvalid && req_tready;
      step.fire    = advance;
      step.last    = s1_last_ff;
      s1_valid_in  = accept || (s1_valid_ff && !advance);
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {{(8-ORDER_W){1'b0}}, rsp_order_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_a_ff <= req_tdata[CP_W-1:0];
         s1_char_b_ff <= req_tdata[2*CP_W-1:CP_W];
         s1_last_ff   <= req_tlast;
      end
      if (advance && s1_last_ff) begin
         rsp_order_ff <= order;
      end
   end

endmodule
